// File: hw/rtl/sorted_list_table_assert.svh
// Assertion macros shared by the sorted list table RTL.
// Plain header: no dependencies, included by the files that carry checks.
`ifndef SORTED_LIST_TABLE_ASSERT_SVH
`define SORTED_LIST_TABLE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define SLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_list_table: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_list_table: next-cycle check failed");

`endif

// File: hw/rtl/slt_pkg.sv
// Shared types and codes for the sorted list table.
// No dependencies; imported by the controller, the cells and the top level.
package slt_pkg;

    localparam int ValueWidth = 32;

    // Command codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_DELETE = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    // Broadcast controls from the sequencer to every cell
    typedef struct packed {
        logic load;   // capture compare flags against the operand
        logic shift;  // move flags one cell towards cell 0
        logic ins;    // open a slot at the position and write the operand
        logic del;    // close the slot at the position
    } t_cell_ctrl;

endpackage

// File: hw/rtl/sorted_list_table.sv
// Top level of the sorted list table: a row of entry cells and a sequencer.
// Depends on slt_pkg, slt_cell and slt_ctrl.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order, one per cell,
// and answers clear, insert, search and delete commands with one result each.
// Inserts land ahead of equal entries; search and delete act on the first
// equal entry. Commands are handled one at a time: clear and an insert into a
// full table go from the load state straight to the finish state; every other
// command first scans for the position, a scan that grows with the number of
// stored entries smaller than the value (at most CAPACITY), by shifting the
// cells' compare flags down the row one cell per cycle. A finished
// result waits in the output register while the next command is taken.
module sorted_list_table #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic signed [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]         s_tuser,   // [1:0] command
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [3:0] position, [8:4] entry_count
    output logic [2:0]         m_tuser    // [1:0] status, [2] found
);
    import slt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    t_cell_ctrl                   w_ctrl;
    logic signed [ValueWidth-1:0] w_value;
    logic [CW-1:0]                w_count;
    logic [IW-1:0]                w_pos;
    logic signed [ValueWidth-1:0] w_entry [CAPACITY];
    logic                         w_less  [CAPACITY];
    logic                         w_match [CAPACITY];

    slt_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .i_less0  (w_less[0]),
        .i_match0 (w_match[0]),
        .o_ctrl   (w_ctrl),
        .o_value  (w_value),
        .o_count  (w_count),
        .o_pos    (w_pos)
    );

    // Row of cells, each linked to its neighbours
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [ValueWidth-1:0] w_prev;
        logic signed [ValueWidth-1:0] w_next;
        logic                         w_next_less;
        logic                         w_next_match;

        if (g == 0) begin : g_first
            assign w_prev = w_entry[g];
        end else begin : g_inner_prev
            assign w_prev = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next       = w_entry[g];
            assign w_next_less  = 1'b0;
            assign w_next_match = 1'b0;
        end else begin : g_inner_next
            assign w_next       = w_entry[g+1];
            assign w_next_less  = w_less[g+1];
            assign w_next_match = w_match[g+1];
        end

        slt_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_value      (w_value),
            .i_count      (w_count),
            .i_pos        (w_pos),
            .i_prev_entry (w_prev),
            .i_next_entry (w_next),
            .i_next_less  (w_next_less),
            .i_next_match (w_next_match),
            .o_entry      (w_entry[g]),
            .o_less       (w_less[g]),
            .o_match      (w_match[g])
        );
    end

endmodule

// File: hw/rtl/slt_cell.sv
// One cell of the sorted row: holds one entry plus its compare flags.
// Depends on slt_pkg for the control struct.
module slt_cell #(
    parameter int CAPACITY = 16,
    parameter int IDX      = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  slt_pkg::t_cell_ctrl             i_ctrl,
    input  logic signed [31:0]              i_value,
    input  logic [$clog2(CAPACITY+1)-1:0]   i_count,
    input  logic [$clog2(CAPACITY)-1:0]     i_pos,
    input  logic signed [31:0]              i_prev_entry,
    input  logic signed [31:0]              i_next_entry,
    input  logic                            i_next_less,
    input  logic                            i_next_match,
    output logic signed [31:0]              o_entry,
    output logic                            o_less,
    output logic                            o_match
);
    import slt_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] MyIdx   = IW'(IDX);
    localparam logic [CW-1:0] MyIdxCw = CW'(IDX);

    logic signed [ValueWidth-1:0] r_entry;
    logic                         r_less;
    logic                         r_match;
    logic                         w_in_use;
    logic                         w_less;
    logic                         w_match;

    // Compare the held entry against the broadcast operand
    assign w_in_use = (i_count > MyIdxCw);
    assign w_less   = w_in_use && (r_entry < i_value);
    assign w_match  = w_in_use && (r_entry == i_value);

    // Capture flags, then pass them down the row one cell a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_less  <= 1'b0;
            r_match <= 1'b0;
        end else if (i_ctrl.load) begin
            r_less  <= w_less;
            r_match <= w_match;
        end else if (i_ctrl.shift) begin
            r_less  <= i_next_less;
            r_match <= i_next_match;
        end
    end

    // Shift entries up for an insert, down for a delete
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            if (MyIdx == i_pos) begin
                r_entry <= i_value;
            end else if (MyIdx > i_pos) begin
                r_entry <= i_prev_entry;
            end
        end else if (i_ctrl.del) begin
            if (MyIdx >= i_pos) begin
                r_entry <= i_next_entry;
            end
        end
    end

    assign o_entry = r_entry;
    assign o_less  = r_less;
    assign o_match = r_match;

endmodule

// File: hw/rtl/slt_ctrl.sv
// Command sequencer for the sorted list table: stream handshakes, scan of
// the cell flags, entry count and result register. Depends on slt_pkg.
`include "sorted_list_table_assert.svh"

module slt_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic signed [31:0]              s_tdata,   // [31:0] value
    input  logic [1:0]                      s_tuser,   // [1:0] command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [3:0] position, [8:4] entry_count
    output logic [2:0]                      m_tuser,   // [1:0] status, [2] found
    input  logic                            i_less0,
    input  logic                            i_match0,
    output slt_pkg::t_cell_ctrl             o_ctrl,
    output logic signed [31:0]              o_value,
    output logic [$clog2(CAPACITY+1)-1:0]   o_count,
    output logic [$clog2(CAPACITY)-1:0]     o_pos
);
    import slt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                       r_state;
    t_cmd                         r_cmd;
    logic signed [ValueWidth-1:0] r_value;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_pos;
    logic                         r_hit;
    logic                         r_full;
    logic                         r_out_valid;
    t_status                      r_out_status;
    logic                         r_out_found;
    logic [3:0]                   r_out_pos;
    logic [4:0]                   r_out_count;

    logic                         w_out_free;
    logic                         w_finish;
    logic [CW-1:0]                n_count;
    t_status                      n_status;
    logic                         n_found;
    logic [3:0]                   n_pos;

    assign w_out_free = !r_out_valid || m_tready;
    assign w_finish   = (r_state == S_FINISH) && w_out_free;

    // Controls broadcast to the cell row
    assign o_ctrl.load  = (r_state == S_LOAD);
    assign o_ctrl.shift = (r_state == S_SCAN) && i_less0;
    assign o_ctrl.ins   = w_finish && (r_cmd == CMD_INSERT) && !r_full;
    assign o_ctrl.del   = w_finish && (r_cmd == CMD_DELETE) && r_hit;
    assign o_value      = r_value;
    assign o_count      = r_count;
    assign o_pos        = r_pos[IW-1:0];

    // Work out the result and the next entry count
    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_found  = 1'b0;
        n_pos    = 4'd0;
        unique case (r_cmd)
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_INSERT: begin
                if (r_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_pos   = 4'(r_pos);
                    n_count = r_count + CW'(1);
                end
            end
            CMD_SEARCH: begin
                if (r_hit) begin
                    n_found = 1'b1;
                    n_pos   = 4'(r_pos);
                end else begin
                    n_status = ST_MISSING;
                end
            end
            CMD_DELETE: begin
                if (r_hit) begin
                    n_found = 1'b1;
                    n_pos   = 4'(r_pos);
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ST_MISSING;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Sequence one command: load flags, scan the row (not for clear or an insert into a full table), commit and report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_hit       <= 1'b0;
            r_full      <= 1'b0;
        end else begin
            // Raise the result when a command commits, drop it once taken
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_cmd   <= t_cmd'(s_tuser);
                        r_value <= s_tdata;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_pos  <= '0;
                    r_hit  <= 1'b0;
                    r_full <= (r_count == CW'(CAPACITY));
                    if ((r_cmd == CMD_CLEAR) ||
                        ((r_cmd == CMD_INSERT) && (r_count == CW'(CAPACITY)))) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_less0) begin
                        r_pos <= r_pos + CW'(1);
                    end else begin
                        r_hit   <= i_match0;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_count      <= n_count;
                        r_out_status <= n_status;
                        r_out_found  <= n_found;
                        r_out_pos    <= n_pos;
                        r_out_count  <= 5'(n_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'd0, r_out_count, r_out_pos};
    assign m_tuser  = {r_out_found, r_out_status};

    // Entry count stays within the row
    `SLT_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    // The scan never runs past the stored entries
    `SLT_ASSERT_IMPL(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_pos <= r_count)
    // A committed insert adds exactly one entry
    `SLT_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, o_ctrl.ins, r_count == $past(r_count) + CW'(1))
    // A committed delete only follows a match and removes one entry
    `SLT_ASSERT_NEXT(a_del_count, i_clk, i_rst_n, o_ctrl.del, r_count == $past(r_count) - CW'(1))

endmodule

// File: test/tb_sorted_list_table.sv
// Testbench for the sorted list table: drives commands on the input stream
// and checks every reply against a behavioural table kept in a scoreboard.
// Depends on slt_pkg and sorted_list_table.
module tb_sorted_list_table;
    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1850;
    localparam int STALL_LIMIT  = 3000;   // cycles with no transfer on either side
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;

    // One expected reply
    typedef struct {
        t_status    status;
        logic       found;
        logic [3:0] position;
        logic [4:0] entry_count;
    } t_table_reply;

    // Behavioural copy of the table plus the queue of replies still due
    class table_scoreboard;
        logic signed [31:0] entries [TABLE_DEPTH];
        int unsigned        count;
        t_table_reply       replies_due[$];
        int                 error_count;

        function new();
            count       = 0;
            error_count = 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function logic signed [31:0] stored_entry();
            return entries[$urandom_range(0, count - 1)];
        endfunction

        // Apply one accepted command and queue the reply it must produce
        function void note_command(t_cmd cmd, logic signed [31:0] value);
            t_table_reply rep;
            int unsigned  idx;
            bit           hit;
            rep.status   = ST_DONE;
            rep.found    = 1'b0;
            rep.position = '0;
            idx          = 0;
            hit          = 1'b0;
            case (cmd)
                CMD_CLEAR: begin
                    count = 0;
                end
                CMD_INSERT: begin
                    if (count >= TABLE_DEPTH) begin
                        rep.status = ST_FULL;
                    end else begin
                        // land ahead of equal entries
                        while (idx < count && entries[idx] < value) idx++;
                        for (int unsigned i = count; i > idx; i--) entries[i] = entries[i - 1];
                        entries[idx] = value;
                        count++;
                        rep.position = idx[3:0];
                    end
                end
                default: begin
                    // search and delete act on the first equal entry
                    for (int unsigned i = 0; i < count; i++) begin
                        if (!hit && entries[i] == value) begin
                            hit = 1'b1;
                            idx = i;
                        end
                    end
                    if (!hit) begin
                        rep.status = ST_MISSING;
                    end else begin
                        rep.found    = 1'b1;
                        rep.position = idx[3:0];
                        if (cmd == CMD_DELETE) begin
                            for (int unsigned i = idx; i + 1 < count; i++)
                                entries[i] = entries[i + 1];
                            count--;
                        end
                    end
                end
            endcase
            rep.entry_count = count[4:0];
            replies_due.push_back(rep);
        endfunction

        // Compare one accepted reply with the oldest one due
        function void check_reply(t_status st, logic fnd, logic [3:0] pos, logic [4:0] cnt);
            t_table_reply exp_rep;
            if (replies_due.size() == 0) begin
                $error("unexpected reply: status %0d found %0d position %0d entry_count %0d",
                       st, fnd, pos, cnt);
                error_count++;
                return;
            end
            exp_rep = replies_due.pop_front();
            if (st !== exp_rep.status) begin
                $error("status: expected %0d, got %0d", exp_rep.status, st);
                error_count++;
            end
            if (fnd !== exp_rep.found) begin
                $error("found: expected %0d, got %0d", exp_rep.found, fnd);
                error_count++;
            end
            if (pos !== exp_rep.position) begin
                $error("position: expected %0d, got %0d", exp_rep.position, pos);
                error_count++;
            end
            if (cnt !== exp_rep.entry_count) begin
                $error("entry_count: expected %0d, got %0d", exp_rep.entry_count, cnt);
                error_count++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic signed [31:0] s_tdata;    // [31:0] value
    logic [1:0]         s_tuser;    // [1:0] command
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;    // [3:0] position, [8:4] entry_count
    logic [2:0]         m_tuser;    // [1:0] status, [2] found

    table_scoreboard sb;
    int  src_idle_pct;
    int  sink_stall_pct;
    bit  hold_req;
    int  hold_left;
    int  quiet_cycles;

    logic signed [31:0] value_pool [8] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1, 5, -5, 1000
    };

    // Directed fill: extremes and duplicates, one per table slot
    logic signed [31:0] fill_values [16] = '{
        32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, -1, 1, 32'sh5555_5555, 32'shAAAA_AAAA,
        7, -7, 1000, -1000, 123456, -123456, 42, 0
    };

    sorted_list_table #(
        .CAPACITY(TABLE_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Clock generation
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one command and hold it until the transfer
    task automatic send_command(input t_cmd cmd, input logic signed [31:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do @(posedge i_clk); while (!s_tready);
        sb.note_command(cmd, value);
    endtask

    // Mostly values likely to match, the rest uniform over the full range
    function automatic logic signed [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return value_pool[$urandom_range(0, 7)];
        if (r < 70 && sb.count > 0) return sb.stored_entry();
        return $urandom;
    endfunction

    // Command mix follows a mode picked at random: growing, shrinking or a middle mix
    function automatic t_cmd pick_command(input int mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2) return CMD_CLEAR;
        if (mode == 0) begin
            if (r < 67) return CMD_INSERT;
            if (r < 84) return CMD_SEARCH;
            return CMD_DELETE;
        end
        if (mode == 1) begin
            if (r < 27) return CMD_INSERT;
            if (r < 50) return CMD_SEARCH;
            return CMD_DELETE;
        end
        if (r < 45) return CMD_INSERT;
        if (r < 72) return CMD_SEARCH;
        return CMD_DELETE;
    endfunction

    // Receiver: random stalls, or a long hold-off on request
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Check each reply transfer
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_reply(t_status'(m_tuser[1:0]), m_tuser[2], m_tdata[3:0], m_tdata[8:4]);
    end

    // Watchdog: give up after a long stretch with no transfer
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial begin
        int per_phase;
        int mode;

        sb             = new();
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_CLEAR;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 1'b0;
        quiet_cycles   = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, fill to capacity with extremes and duplicates,
        // insert into a full table, hits on duplicates, misses, clear
        send_command(CMD_CLEAR, 0);
        send_command(CMD_SEARCH, 5);
        send_command(CMD_DELETE, 5);
        foreach (fill_values[i]) send_command(CMD_INSERT, fill_values[i]);
        send_command(CMD_INSERT, 99);
        send_command(CMD_SEARCH, 0);
        send_command(CMD_DELETE, 0);
        send_command(CMD_DELETE, 77);
        send_command(CMD_SEARCH, 77);
        send_command(CMD_DELETE, 32'sh7FFF_FFFF);
        send_command(CMD_CLEAR, 32'sh1234_5678);

        // Random: four idling phases, the first opening with a long hold-off
        per_phase = RANDOM_ITEMS / 4;
        mode      = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  hold_req = 1'b1; end
                1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
                default: begin src_idle_pct = 34; sink_stall_pct = 34; end
            endcase
            for (int n = 0; n < per_phase; n++) begin
                if (n % 40 == 0) mode = $urandom_range(0, 2);
                send_command(pick_command(mode), pick_value());
            end
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;

        // Drain outstanding replies, then wait for any stray reply before the final check
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $error("%0d replies never arrived", sb.pending());
            sb.error_count++;
        end
        if (sb.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/slt_pkg.sv
hw/rtl/slt_cell.sv
hw/rtl/slt_ctrl.sv
hw/rtl/sorted_list_table.sv
test/tb_sorted_list_table.sv
